// ===== hw/rtl/u8dv_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 validating decoder.
`default_nettype none

package u8dv_pkg;

  localparam int MAX_SEQ_BYTES = 6;
  localparam int LANES         = MAX_SEQ_BYTES - 1;
  localparam int AVAIL_W       = 3;
  localparam int LEN_W         = 3;
  localparam int CP_W          = 21;

  localparam logic [AVAIL_W-1:0] AVAIL_MAX = AVAIL_W'(MAX_SEQ_BYTES);

  localparam logic [CP_W-1:0] CP_LIMIT  = 21'h110000;
  localparam logic [CP_W-1:0] NCHAR_LO  = 21'h00FDD0;
  localparam logic [CP_W-1:0] NCHAR_HI  = 21'h00FDEF;
  localparam logic [CP_W-1:0] MIN_2B    = 21'h000080;
  localparam logic [CP_W-1:0] MIN_3B    = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4B    = 21'h010000;
  localparam logic [9:0]      SURR_TAG  = 10'h01B;
  localparam logic [14:0]     NONCH_TAG = 15'h7FFF;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  typedef struct packed {
    logic       short_bad;
    logic       form_bad;
    logic       nul;
    logic [5:0] payload;
  } lane_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    status_t          status;
  } result_t;

  // 0 marks a lead byte that cannot open a sequence
  function automatic logic [LEN_W-1:0] lead_len(input logic [7:0] lead);
    logic [LEN_W-1:0] len;
    if (lead < 8'h80) begin
      len = LEN_W'(1);
    end else if (lead < 8'hC0) begin
      len = '0;
    end else if (lead < 8'hE0) begin
      len = LEN_W'(2);
    end else if (lead < 8'hF0) begin
      len = LEN_W'(3);
    end else if (lead < 8'hF8) begin
      len = LEN_W'(4);
    end else if (lead < 8'hFC) begin
      len = LEN_W'(5);
    end else if (lead < 8'hFE) begin
      len = LEN_W'(6);
    end else begin
      len = '0;
    end
    return len;
  endfunction

  function automatic logic [AVAIL_W-1:0] clamp_avail(input logic [AVAIL_W-1:0] avail);
    return (avail > AVAIL_MAX) ? AVAIL_MAX : avail;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/u8dv_in_if.sv =====
// Input channel: six-byte window and byte count.
`default_nettype none

interface u8dv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte3;
  logic [7:0] byte4;
  logic [7:0] byte5;
  logic [u8dv_pkg::AVAIL_W-1:0] avail;

  modport source (output valid, byte0, byte1, byte2, byte3, byte4, byte5, avail,
                  input ready);
  modport sink   (input valid, byte0, byte1, byte2, byte3, byte4, byte5, avail,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u8dv_out_if.sv =====
// Result channel: code point, sequence length and status.
`default_nettype none

interface u8dv_out_if;
  logic                         valid;
  logic                         ready;
  logic [u8dv_pkg::CP_W-1:0]    code_point;
  logic [u8dv_pkg::LEN_W-1:0]   seq_length;
  u8dv_pkg::status_t            status;

  modport source (output valid, code_point, seq_length, status, input ready);
  modport sink   (input valid, code_point, seq_length, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u8dv_lane.sv =====
// Per-byte lane: classifies one trailing byte of the window.
`default_nettype none

module u8dv_lane #(
  parameter int LANE_POS = 1
) (
  input  wire logic [7:0]                   byte_i,
  input  wire logic [u8dv_pkg::AVAIL_W-1:0] avail_i,
  input  wire logic [u8dv_pkg::LEN_W-1:0]   form_len_i,
  output u8dv_pkg::lane_t                   lane_o
);

  logic is_cont;
  logic present;
  logic in_form;

  assign is_cont = (byte_i & u8dv_pkg::CONT_MASK) == u8dv_pkg::CONT_TAG;
  assign present = u8dv_pkg::AVAIL_W'(LANE_POS) < avail_i;
  assign in_form = u8dv_pkg::LEN_W'(LANE_POS) < form_len_i;

  assign lane_o.short_bad = present && !is_cont;
  assign lane_o.form_bad  = in_form && !is_cont;
  assign lane_o.nul       = byte_i == 8'h00;
  assign lane_o.payload   = byte_i[5:0];

endmodule

`default_nettype wire

// ===== hw/rtl/u8dv_merge.sv =====
// Merge stage: combines lane flags with the lead byte into one result.
`default_nettype none

module u8dv_merge (
  input  wire logic [7:0]                   lead_i,
  input  wire logic [u8dv_pkg::AVAIL_W-1:0] avail_i,
  input  wire logic [u8dv_pkg::LEN_W-1:0]   form_len_i,
  input  wire u8dv_pkg::lane_t              lanes_i [u8dv_pkg::LANES],
  output u8dv_pkg::result_t                 result_o
);

  logic                      any_short_bad;
  logic                      first_bad;
  logic                      first_nul;
  logic [u8dv_pkg::CP_W-1:0] value;
  logic                      overlong;
  logic                      value_ok;

  always_comb begin
    any_short_bad = 1'b0;
    first_bad     = 1'b0;
    first_nul     = 1'b0;
    for (int i = u8dv_pkg::LANES - 1; i >= 0; i--) begin
      any_short_bad = any_short_bad | lanes_i[i].short_bad;
      if (lanes_i[i].form_bad) begin
        first_bad = 1'b1;
        first_nul = lanes_i[i].nul;
      end
    end
  end

  always_comb begin
    case (form_len_i)
      3'd2: begin
        value    = {10'b0, lead_i[4:0], lanes_i[0].payload};
        overlong = value < u8dv_pkg::MIN_2B;
      end
      3'd3: begin
        value    = {5'b0, lead_i[3:0], lanes_i[0].payload, lanes_i[1].payload};
        overlong = value < u8dv_pkg::MIN_3B;
      end
      3'd4: begin
        value    = {lead_i[2:0], lanes_i[0].payload, lanes_i[1].payload,
                    lanes_i[2].payload};
        overlong = value < u8dv_pkg::MIN_4B;
      end
      default: begin
        value    = '0;
        overlong = 1'b1;
      end
    endcase
    value_ok = !overlong
            && (value < u8dv_pkg::CP_LIMIT)
            && (value[20:11] != u8dv_pkg::SURR_TAG)
            && !((value >= u8dv_pkg::NCHAR_LO) && (value <= u8dv_pkg::NCHAR_HI))
            && (value[15:1] != u8dv_pkg::NONCH_TAG);
  end

  always_comb begin
    result_o.code_point = '0;
    result_o.seq_length = '0;
    result_o.status     = u8dv_pkg::ST_INVALID;
    if (avail_i == '0) begin
      result_o.status = u8dv_pkg::ST_TRUNC;
    end else if (form_len_i == u8dv_pkg::LEN_W'(1)) begin
      result_o.code_point = u8dv_pkg::CP_W'(lead_i);
      result_o.seq_length = form_len_i;
      result_o.status     = u8dv_pkg::ST_OK;
    end else if (form_len_i == '0) begin
      result_o.status = u8dv_pkg::ST_INVALID;
    end else if (form_len_i > avail_i) begin
      result_o.status = any_short_bad ? u8dv_pkg::ST_INVALID : u8dv_pkg::ST_TRUNC;
    end else if (first_bad) begin
      result_o.status = first_nul ? u8dv_pkg::ST_TRUNC : u8dv_pkg::ST_INVALID;
    end else if (value_ok) begin
      result_o.code_point = value;
      result_o.seq_length = form_len_i;
      result_o.status     = u8dv_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_decode_validated_top.sv =====
// Validating UTF-8 decoder top level: lanes, merge stage and output buffering.
//
// Usage:
//   in_ch carries a six-byte window (byte0 is the lead byte) and avail, the
//   number of bytes present (values above six count as six). out_ch returns
//   one item per input item: code_point, seq_length (1..4) and status ok, or
//   zero fields with status invalid or truncated.
//   Both channels use valid/ready; an item moves when both are high.
//   Five lanes classify byte1..byte5 in parallel; a merge stage forms the
//   result, which lands in an output register.
//   Each result is registered in the output register, or in the skid register during a stall.
//   Throughput: 1 item per cycle while out_ch.ready stays high.
//   When the receiver stalls, one more item is taken into a skid register;
//   in_ch.ready then drops until the output register drains.
//   Reset (rst_n low, synchronous) empties both registers; no item is lost
//   or repeated across a stall.
`default_nettype none

module utf8_decode_validated_top (
  input wire logic   clk,
  input wire logic   rst_n,
  u8dv_in_if.sink    in_ch,
  u8dv_out_if.source out_ch
);

  logic [7:0]                   win [u8dv_pkg::MAX_SEQ_BYTES];
  logic [u8dv_pkg::AVAIL_W-1:0] avail_c;
  logic [u8dv_pkg::LEN_W-1:0]   form_len;
  u8dv_pkg::lane_t              lanes [u8dv_pkg::LANES];
  u8dv_pkg::result_t            result;

  u8dv_pkg::result_t out_r,   out_nxt;
  u8dv_pkg::result_t skid_r,  skid_nxt;
  logic              out_v_r, out_v_nxt;
  logic              skid_v_r, skid_v_nxt;
  logic              in_accept;
  logic              out_free;

  assign win[0] = in_ch.byte0;
  assign win[1] = in_ch.byte1;
  assign win[2] = in_ch.byte2;
  assign win[3] = in_ch.byte3;
  assign win[4] = in_ch.byte4;
  assign win[5] = in_ch.byte5;

  assign avail_c  = u8dv_pkg::clamp_avail(in_ch.avail);
  assign form_len = u8dv_pkg::lead_len(win[0]);

  for (genvar g = 0; g < u8dv_pkg::LANES; g++) begin : g_lane
    u8dv_lane #(
      .LANE_POS (g + 1)
    ) u_lane (
      .byte_i     (win[g+1]),
      .avail_i    (avail_c),
      .form_len_i (form_len),
      .lane_o     (lanes[g])
    );
  end

  u8dv_merge u_merge (
    .lead_i     (win[0]),
    .avail_i    (avail_c),
    .form_len_i (form_len),
    .lanes_i    (lanes),
    .result_o   (result)
  );

  assign in_ch.ready = !skid_v_r;
  assign in_accept   = in_ch.valid && !skid_v_r;
  assign out_free    = !out_v_r || out_ch.ready;

  always_comb begin
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (out_free) begin
      out_v_nxt  = skid_v_r || in_accept;
      out_nxt    = skid_v_r ? skid_r : result;
      skid_v_nxt = 1'b0;
    end else if (in_accept) begin
      skid_nxt   = result;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.code_point = out_r.code_point;
  assign out_ch.seq_length = out_r.seq_length;
  assign out_ch.status     = out_r.status;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds an item while output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready && in_accept) |=> skid_v_r)
    else $error("item accepted during stall was not held in skid register");

  a_empty_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_v_r && in_accept) |=> (out_v_r && !skid_v_r))
    else $error("item accepted into empty buffer did not reach output register");

  a_ok_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.status == u8dv_pkg::ST_OK) |-> (out_r.seq_length != '0))
    else $error("ok result carries zero sequence length");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the validating UTF-8 decoder: directed windows, random traffic, stalls.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 2000;

  typedef struct packed {
    logic [5:0][7:0] b;
    logic [2:0]      avail;
  } window_t;

  logic clk = 1'b0;
  logic rst_n;

  u8dv_in_if  in_ch();
  u8dv_out_if out_ch();

  utf8_decode_validated_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  u8dv_pkg::result_t expected_chars[$];
  u8dv_pkg::result_t want;
  int      mismatches = 0;
  int      stuck_cycles = 0;
  int      holds_asked = 0;
  int      holds_served = 0;
  bit      tx_gaps = 1'b0;
  bit      rx_stalls = 1'b0;

  always #5 clk = ~clk;

  function automatic logic [31:0] form_floor(int len);
    case (len)
      2: return 32'h80;
      3: return 32'h800;
      4: return 32'h10000;
      5: return 32'h200000;
      6: return 32'h4000000;
      default: return 32'h0;
    endcase
  endfunction

  function automatic u8dv_pkg::result_t decode_utf8(window_t w);
    u8dv_pkg::result_t r;
    int          n;
    int          len;
    int          k;
    logic [7:0]  lead;
    logic [7:0]  c;
    logic [31:0] v;
    r = '0;
    n = (w.avail > 3'd6) ? 6 : int'(w.avail);
    lead = w.b[0];
    if (n == 0) begin
      r.status = u8dv_pkg::ST_TRUNC;
      return r;
    end
    if (lead < 8'h80) begin
      r.code_point = 21'(lead);
      r.seq_length = 3'd1;
      r.status = u8dv_pkg::ST_OK;
      return r;
    end
    r.status = u8dv_pkg::ST_INVALID;
    if (lead < 8'hC0 || lead >= 8'hFE) return r;
    if (lead < 8'hE0) len = 2;
    else if (lead < 8'hF0) len = 3;
    else if (lead < 8'hF8) len = 4;
    else if (lead < 8'hFC) len = 5;
    else len = 6;
    v = 32'(lead) & ((32'h1 << (7 - len)) - 32'h1);
    if (len > n) begin
      for (k = 1; k < n; k++) begin
        if (w.b[k][7:6] != 2'b10) return r;
      end
      r.status = u8dv_pkg::ST_TRUNC;
      return r;
    end
    for (k = 1; k < len; k++) begin
      c = w.b[k];
      if (c[7:6] != 2'b10) begin
        if (c == 8'h00) r.status = u8dv_pkg::ST_TRUNC;
        return r;
      end
      v = (v << 6) | 32'(c[5:0]);
    end
    if (v < form_floor(len) || v >= 32'h110000 || v[31:11] == 21'h1B ||
        (v >= 32'hFDD0 && v <= 32'hFDEF) || v[15:1] == 15'h7FFF) return r;
    r.code_point = v[20:0];
    r.seq_length = 3'(len);
    r.status = u8dv_pkg::ST_OK;
    return r;
  endfunction

  function automatic window_t make_seq(logic [31:0] v, int len, logic [2:0] avail);
    window_t w;
    int      k;
    for (k = 0; k < 6; k++) w.b[k] = 8'($urandom);
    w.avail = avail;
    if (len == 1) begin
      w.b[0] = {1'b0, v[6:0]};
    end else begin
      w.b[0] = 8'(8'hFF << (8 - len)) |
               8'((v >> (6 * (len - 1))) & ((32'h1 << (7 - len)) - 32'h1));
      for (k = 1; k < len; k++) w.b[k] = 8'h80 | 8'((v >> (6 * (len - 1 - k))) & 32'h3F);
    end
    return w;
  endfunction

  function automatic window_t raw_window(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                         logic [2:0] avail);
    window_t w;
    w = make_seq(32'h0, 1, avail);
    w.b[0] = b0;
    w.b[1] = b1;
    w.b[2] = b2;
    return w;
  endfunction

  function automatic logic [7:0] non_cont_byte();
    logic [7:0] c;
    c = 8'($urandom);
    if ($urandom_range(0, 2) == 0) c = 8'h00;
    else if (c[7:6] == 2'b10) c[6] = 1'b1;
    return c;
  endfunction

  function automatic window_t random_window();
    window_t     w;
    logic [31:0] v;
    int          len;
    int          k;
    int          shape;
    shape = $urandom_range(0, 99);
    if (shape < 15) begin
      for (k = 0; k < 6; k++) w.b[k] = 8'($urandom);
      w.avail = 3'($urandom);
      return w;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: len = 1;
      3, 4:    len = 2;
      5, 6:    len = 3;
      7, 8:    len = 4;
      default: len = $urandom_range(5, 6);
    endcase
    v = $urandom & ((32'h1 << ((len == 1) ? 7 : 5 * len + 1)) - 32'h1);
    if (len > 1) begin
      case ($urandom_range(0, 11))
        0: v = 32'hD800 + $urandom_range(0, 32'h7FF);
        1: v = 32'hFDD0 + $urandom_range(0, 31);
        2: v = ($urandom_range(0, 16) << 16) | 32'hFFFE | $urandom_range(0, 1);
        3: v = 32'h110000 + $urandom_range(0, 32'hEFFFF);
        4: v = form_floor(len) - $urandom_range(0, 1);
        5: v = $urandom_range(0, form_floor(len) - 1);
        default: ;
      endcase
    end
    w = make_seq(v, len, 3'($urandom_range(len, 7)));
    if (shape >= 75 && len > 1) begin
      k = $urandom_range(1, len - 1);
      case ($urandom_range(0, 2))
        0: w.avail = 3'($urandom_range(1, len - 1));
        1: w.b[k] = non_cont_byte();
        default: begin
          w.b[k] = non_cont_byte();
          w.avail = 3'($urandom_range(1, len - 1));
        end
      endcase
    end
    return w;
  endfunction

  task automatic send_window(input window_t w);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte0 <= w.b[0];
    in_ch.byte1 <= w.b[1];
    in_ch.byte2 <= w.b[2];
    in_ch.byte3 <= w.b[3];
    in_ch.byte4 <= w.b[4];
    in_ch.byte5 <= w.b[5];
    in_ch.avail <= w.avail;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic test_random(int count, bit gaps, bit stalls);
    tx_gaps = gaps;
    rx_stalls = stalls;
    repeat (count) send_window(random_window());
  endtask

  task automatic test_directed();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    // single-byte forms, NUL, empty window, avail of seven
    send_window(make_seq(32'h0, 1, 3'd1));
    send_window(make_seq(32'h7F, 1, 3'd7));
    send_window(make_seq(32'h41, 1, 3'd0));
    // bad lead bytes
    send_window(raw_window(8'h80, 8'h80, 8'h80, 3'd6));
    send_window(raw_window(8'hBF, 8'h80, 8'h80, 3'd6));
    send_window(raw_window(8'hFE, 8'h80, 8'h80, 3'd6));
    send_window(raw_window(8'hFF, 8'hBF, 8'hBF, 3'd6));
    // form boundaries and overlong forms
    send_window(make_seq(32'h80, 2, 3'd2));
    send_window(make_seq(32'h7FF, 2, 3'd6));
    send_window(make_seq(32'h7F, 2, 3'd2));
    send_window(make_seq(32'h800, 3, 3'd3));
    send_window(make_seq(32'h7FF, 3, 3'd3));
    send_window(make_seq(32'hFFFF, 4, 3'd4));
    send_window(make_seq(32'h10000, 4, 3'd4));
    send_window(make_seq(32'h10FFFD, 4, 3'd5));
    // surrogates, noncharacters, out of range
    send_window(make_seq(32'hD800, 3, 3'd3));
    send_window(make_seq(32'hFDD0, 3, 3'd3));
    send_window(make_seq(32'hFFFE, 3, 3'd6));
    send_window(make_seq(32'h110000, 4, 3'd4));
    // five- and six-byte forms
    send_window(make_seq(32'h200000, 5, 3'd5));
    send_window(make_seq(32'h7FFFFFFF, 6, 3'd7));
    // short window and broken sequence, with and without NUL
    send_window(raw_window(8'hE2, 8'h82, 8'h00, 3'd2));
    send_window(raw_window(8'hE2, 8'h00, 8'hAC, 3'd2));
    send_window(raw_window(8'hE2, 8'h00, 8'hAC, 3'd3));
    send_window(raw_window(8'hE2, 8'h41, 8'hAC, 3'd3));
    wait_drain();
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    holds_asked++;
    @(posedge clk);
    repeat (12) send_window(random_window());
    wait_drain();
  endtask

  task automatic test_idle_traffic();
    test_random(700, 1'b1, 1'b1);
    test_random(150, 1'b1, 1'b0);
    test_random(150, 1'b0, 1'b1);
  endtask

  task automatic test_drain_pause();
    test_random(100, 1'b1, 1'b1);
    wait_drain();
    test_random(100, 1'b1, 1'b1);
  endtask

  task automatic test_streaming();
    test_random(600, 1'b0, 1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.byte0 = '0;
    in_ch.byte1 = '0;
    in_ch.byte2 = '0;
    in_ch.byte3 = '0;
    in_ch.byte4 = '0;
    in_ch.byte5 = '0;
    in_ch.avail = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_idle_traffic();
    test_drain_pause();
    test_streaming();
    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("PASS utf8_decode_validated_top");
    end else begin
      $display("FAIL utf8_decode_validated_top");
    end
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_chars.push_back(decode_utf8({in_ch.byte5, in_ch.byte4, in_ch.byte3,
                                            in_ch.byte2, in_ch.byte1, in_ch.byte0,
                                            in_ch.avail}));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item cp=%h len=%0d status=%0d", $time,
                 out_ch.code_point, out_ch.seq_length, out_ch.status);
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.code_point !== want.code_point) begin
          mismatches++;
          $display("%0t: code_point expected %h actual %h", $time,
                   want.code_point, out_ch.code_point);
        end
        if (out_ch.seq_length !== want.seq_length) begin
          mismatches++;
          $display("%0t: seq_length expected %0d actual %0d", $time,
                   want.seq_length, out_ch.seq_length);
        end
        if (out_ch.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_ch.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAIL utf8_decode_validated_top");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

endmodule
